### rtl/integer_to_radix_ascii_core_macros.svh
// Assertion macros for the integer-to-ASCII core.
// Expects signals named clock and reset in the module that uses them.
`ifndef INTEGER_TO_RADIX_ASCII_CORE_MACROS_SVH
`define INTEGER_TO_RADIX_ASCII_CORE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ITRA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ITRA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

### rtl/itra_pkg.sv
// Shared types, constants and helpers for the integer-to-ASCII core.
// No dependencies; used by the front, back and top-level modules.
`default_nettype none

package itra_pkg;

   // Conversion width and field widths
   localparam int ITRA_VALUE_WIDTH = 32;
   localparam int ITRA_RADIX_W     = 6;
   localparam int ITRA_CHAR_W      = 8;
   localparam int ITRA_DIGIT_W     = 6;

   // Long division: bits retired per cycle and division steps per digit
   localparam int ITRA_STEP_BITS  = 8;
   localparam int ITRA_DIV_STEPS  = (ITRA_VALUE_WIDTH + ITRA_STEP_BITS - 1) / ITRA_STEP_BITS;
   localparam int ITRA_WORK_W     = ITRA_DIV_STEPS * ITRA_STEP_BITS;
   localparam int ITRA_STEP_CNT_W = (ITRA_DIV_STEPS > 1) ? $clog2(ITRA_DIV_STEPS) : 1;

   // Digit stack: radix 2 gives one digit per magnitude bit
   localparam int ITRA_STACK_DEPTH = ITRA_VALUE_WIDTH;
   localparam int ITRA_IDX_W       = $clog2(ITRA_STACK_DEPTH);
   localparam int ITRA_CNT_W       = $clog2(ITRA_STACK_DEPTH + 1);

   // Queue between front and back
   localparam int ITRA_QUEUE_DEPTH = 2;
   localparam int ITRA_QPTR_W      = $clog2(ITRA_QUEUE_DEPTH);
   localparam int ITRA_QCNT_W      = $clog2(ITRA_QUEUE_DEPTH + 1);

   // Radix limits and character codes
   localparam logic [ITRA_RADIX_W-1:0] RADIX_MIN  = 6'd2;
   localparam logic [ITRA_RADIX_W-1:0] RADIX_MAX  = 6'd36;
   localparam logic [ITRA_DIGIT_W-1:0] DEC_BASE   = 6'd10;
   localparam logic [ITRA_CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
   localparam logic [ITRA_CHAR_W-1:0]  CHAR_A     = 8'h41;
   localparam logic [ITRA_CHAR_W-1:0]  CHAR_MINUS = 8'h2D;

   // One classified number waiting for conversion
   typedef struct packed {
      logic [ITRA_VALUE_WIDTH-1:0] mag;
      logic [ITRA_RADIX_W-1:0]     radix;
      logic                        negative;
   } itra_item_type;

   // Head of the queue as seen by the back end
   typedef struct packed {
      logic          valid;
      itra_item_type item;
   } itra_qhead_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_EMIT
   } itra_state_type;

   // Map a digit value to its ASCII code
   function automatic logic [ITRA_CHAR_W-1:0] digit_char(input logic [ITRA_DIGIT_W-1:0] d);
      logic [ITRA_CHAR_W-1:0] dc;
      dc = ITRA_CHAR_W'(d);
      if (d < DEC_BASE) begin
         return CHAR_ZERO + dc;
      end
      return CHAR_A + dc - ITRA_CHAR_W'(DEC_BASE);
   endfunction

endpackage

`default_nettype wire

### rtl/itra_front.sv
// Front end: accepts numbers, clamps the radix, splits sign and magnitude,
// and holds them in a short queue for the back end. Uses itra_pkg.
`default_nettype none

module itra_front (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_push,
   output logic                                         req_full,
   input  wire logic signed [itra_pkg::ITRA_VALUE_WIDTH-1:0] req_value,
   input  wire logic [itra_pkg::ITRA_RADIX_W-1:0]       req_radix,
   output itra_pkg::itra_qhead_type                     q_head,
   input  wire logic                                    q_pop
);
   import itra_pkg::*;

   itra_item_type                item_cls;
   itra_item_type                queue_ff [ITRA_QUEUE_DEPTH];
   logic [ITRA_QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [ITRA_QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [ITRA_QCNT_W-1:0]       count_ff, count_in;
   logic                         do_push;
   logic                         do_pop;
   logic [ITRA_VALUE_WIDTH-1:0]  raw;

   // Classify: sign, unsigned magnitude, clamped radix
   always_comb begin
      raw               = req_value;
      item_cls.negative = raw[ITRA_VALUE_WIDTH-1];
      item_cls.mag      = item_cls.negative ? (~raw + 1'b1) : raw;
      if (req_radix < RADIX_MIN) begin
         item_cls.radix = RADIX_MIN;
      end else if (req_radix > RADIX_MAX) begin
         item_cls.radix = RADIX_MAX;
      end else begin
         item_cls.radix = req_radix;
      end
   end

   assign req_full = (count_ff == ITRA_QCNT_W'(ITRA_QUEUE_DEPTH));
   assign do_push  = req_push && !req_full;
   assign do_pop   = q_pop && (count_ff != '0);

   assign q_head.valid = (count_ff != '0);
   assign q_head.item  = queue_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= item_cls;
      end
   end

endmodule

`default_nettype wire

### rtl/itra_back.sv
// Back end: long division by the radix, a few bits per cycle, digits kept on a
// stack, then characters sent most significant first. Uses itra_pkg.
`default_nettype none

module itra_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire itra_pkg::itra_qhead_type          q_head,
   output logic                                   q_pop,
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output logic [itra_pkg::ITRA_CHAR_W-1:0]       rsp_character,
   output logic                                   rsp_last
);
   import itra_pkg::*;

   itra_state_type              state_ff, state_in;
   logic [ITRA_WORK_W-1:0]      work_ff, work_in;
   logic [ITRA_DIGIT_W-1:0]     rem_ff, rem_in;
   logic [ITRA_RADIX_W-1:0]     radix_ff, radix_in;
   logic                        neg_ff, neg_in;
   logic [ITRA_STEP_CNT_W-1:0]  step_ff, step_in;
   logic [ITRA_CNT_W-1:0]       cnt_ff, cnt_in;
   logic [ITRA_DIGIT_W-1:0]     stack_ff [ITRA_STACK_DEPTH];
   logic                        out_valid_ff, out_valid_in;
   logic [ITRA_CHAR_W-1:0]      out_char_ff, out_char_in;
   logic                        out_last_ff, out_last_in;

   logic                        can_load;
   logic                        last_step;
   logic [ITRA_WORK_W-1:0]      div_work;
   logic [ITRA_DIGIT_W-1:0]     div_rem;
   logic                        quot_zero;
   logic                        push_digit;
   logic [ITRA_CNT_W-1:0]       top_cnt;
   logic [ITRA_DIGIT_W-1:0]     top_digit;

   assign can_load  = !out_valid_ff || rsp_pop;
   assign last_step = (step_ff == ITRA_STEP_CNT_W'(ITRA_DIV_STEPS - 1));
   assign top_cnt   = cnt_ff - 1'b1;
   assign top_digit = stack_ff[top_cnt[ITRA_IDX_W-1:0]];

   // Retire STEP_BITS dividend bits: shift in, compare, subtract
   always_comb begin
      logic [ITRA_DIGIT_W:0] trial;
      div_work = work_ff;
      div_rem  = rem_ff;
      for (int i = 0; i < ITRA_STEP_BITS; i++) begin
         trial    = {div_rem, div_work[ITRA_WORK_W-1]};
         div_work = {div_work[ITRA_WORK_W-2:0], 1'b0};
         if (trial >= {1'b0, radix_ff}) begin
            trial       = trial - {1'b0, radix_ff};
            div_work[0] = 1'b1;
         end
         div_rem = trial[ITRA_DIGIT_W-1:0];
      end
      quot_zero = (div_work == '0);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_head.valid) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (last_step && quot_zero) begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (can_load) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (can_load && cnt_ff == ITRA_CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and output register controls
   always_comb begin
      q_pop        = 1'b0;
      push_digit   = 1'b0;
      work_in      = work_ff;
      rem_in       = rem_ff;
      radix_in     = radix_ff;
      neg_in       = neg_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      out_valid_in = rsp_pop ? 1'b0 : out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_head.valid) begin
               q_pop    = 1'b1;
               work_in  = ITRA_WORK_W'(q_head.item.mag);
               radix_in = q_head.item.radix;
               neg_in   = q_head.item.negative;
               rem_in   = '0;
               step_in  = '0;
               cnt_in   = '0;
            end
         end
         ST_DIVIDE: begin
            work_in = div_work;
            if (last_step) begin
               push_digit = 1'b1;
               rem_in     = '0;
               step_in    = '0;
               cnt_in     = cnt_ff + 1'b1;
            end else begin
               rem_in  = div_rem;
               step_in = step_ff + 1'b1;
            end
         end
         ST_SIGN: begin
            if (can_load) begin
               out_valid_in = 1'b1;
               out_char_in  = CHAR_MINUS;
               out_last_in  = 1'b0;
            end
         end
         ST_EMIT: begin
            if (can_load) begin
               out_valid_in = 1'b1;
               out_char_in  = digit_char(top_digit);
               out_last_in  = (cnt_ff == ITRA_CNT_W'(1));
               cnt_in       = top_cnt;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         step_ff      <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      rem_ff      <= rem_in;
      radix_ff    <= radix_in;
      neg_ff      <= neg_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   // Push each finished digit, least significant first
   always_ff @(posedge clock) begin
      if (push_digit) begin
         stack_ff[cnt_ff[ITRA_IDX_W-1:0]] <= div_rem;
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_character = out_char_ff;
   assign rsp_last      = out_last_ff;

endmodule

`default_nettype wire

### rtl/integer_to_radix_ascii_core.sv
// Integer to ASCII text in radix 2..36. Numbers wait in the front queue; the
// back end loads one, runs a 32-bit long division per digit, 8 bits a cycle,
// then sends the characters, and takes no new number until the last character
// of the current one is in the output register. Synchronous reset empties the
// queue and the output register; payload storage is not cleared.
`default_nettype none
`include "integer_to_radix_ascii_core_macros.svh"

module integer_to_radix_ascii_core (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   input  wire logic                                         req_push,
   output logic                                              req_full,
   input  wire logic signed [itra_pkg::ITRA_VALUE_WIDTH-1:0] req_value,
   input  wire logic [itra_pkg::ITRA_RADIX_W-1:0]            req_radix,
   output logic                                              rsp_empty,
   input  wire logic                                         rsp_pop,
   output logic [itra_pkg::ITRA_CHAR_W-1:0]                  rsp_character,
   output logic                                              rsp_last
);
   import itra_pkg::*;

   itra_qhead_type q_head;
   logic           q_pop;

   itra_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_value (req_value),
      .req_radix (req_radix),
      .q_head    (q_head),
      .q_pop     (q_pop)
   );

   itra_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   // Output register is empty right after reset
   `ITRA_ASSERT_ALWAYS(a_empty_after_reset, reset |=> rsp_empty, "result waiting after reset")
   // Back end takes from the queue only when it holds an item
   `ITRA_ASSERT(a_pop_has_item, q_pop |-> q_head.valid, "queue popped while empty")
   // A minus sign is never the final character
   `ITRA_ASSERT(a_sign_not_last, rsp_empty || !rsp_last || rsp_character != CHAR_MINUS, "sign last")

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking bench for integer_to_radix_ascii_core: signed values go in, ASCII text comes out.
// Holds its own text predictor and compares every character beat against it.
// Depends on itra_pkg and the core RTL only.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import itra_pkg::*;

   localparam int VW            = ITRA_VALUE_WIDTH;
   localparam int DIGIT_SLOTS   = 64;
   localparam int IDLE_LIMIT    = 4000;
   localparam int DRAIN_CYCLES  = 200;
   localparam int REPORT_CAP    = 100;

   // One character beat of expected text
   typedef struct {
      logic [ITRA_CHAR_W-1:0] code;
      logic                   last;
   } text_beat_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_push = 1'b0;
   logic                           req_full;
   logic signed [VW-1:0]           req_value = '0;
   logic [ITRA_RADIX_W-1:0]        req_radix = '0;
   logic                           rsp_empty;
   logic                           rsp_pop = 1'b0;
   logic [ITRA_CHAR_W-1:0]         rsp_character;
   logic                           rsp_last;

   text_beat_type expected_text[$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int numbers_sent  = 0;
   int chars_checked = 0;
   int error_count   = 0;
   int stall_cycles  = 0;

   integer_to_radix_ascii_core u_top (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_value     (req_value),
      .req_radix     (req_radix),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   always #10 clock = ~clock;

   // Work out the text of one number and queue its character beats
   function automatic void predict_text(input logic [VW-1:0] value,
                                        input logic [ITRA_RADIX_W-1:0] radix);
      logic [VW-1:0]           mag;
      logic [VW-1:0]           rem;
      logic [ITRA_RADIX_W-1:0] base;
      logic [ITRA_CHAR_W-1:0]  digit_codes[DIGIT_SLOTS];
      int                      count;
      int                      k;
      text_beat_type           beat;
      base = radix;
      if (base < RADIX_MIN) begin
         base = RADIX_MIN;
      end else if (base > RADIX_MAX) begin
         base = RADIX_MAX;
      end
      // magnitude taken unsigned, so the most negative value needs no special path
      mag = value[VW-1] ? (~value + 1'b1) : value;
      count = 0;
      if (mag == '0) begin
         digit_codes[0] = CHAR_ZERO;
         count = 1;
      end
      // digits come out least significant first
      while (mag != '0) begin
         rem = mag % VW'(base);
         if (rem < VW'(DEC_BASE)) begin
            digit_codes[count] = CHAR_ZERO + ITRA_CHAR_W'(rem);
         end else begin
            digit_codes[count] = CHAR_A + ITRA_CHAR_W'(rem) - ITRA_CHAR_W'(DEC_BASE);
         end
         mag = mag / VW'(base);
         count++;
      end
      if (value[VW-1]) begin
         beat.code = CHAR_MINUS;
         beat.last = 1'b0;
         expected_text.push_back(beat);
      end
      for (k = count - 1; k >= 0; k--) begin
         beat.code = digit_codes[k];
         beat.last = (k == 0);
         expected_text.push_back(beat);
      end
   endfunction

   // Present one number and hold it until the core takes the beat
   task automatic send_number(input logic [VW-1:0] value, input logic [ITRA_RADIX_W-1:0] radix);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push  <= 1'b1;
      req_value <= value;
      req_radix <= radix;
      do begin
         @(posedge clock);
      end while (req_full);
      predict_text(value, radix);
      numbers_sent++;
   endtask

   // Drop push after the last beat
   task automatic release_input();
      @(negedge clock);
      req_push <= 1'b0;
   endtask

   function automatic logic [VW-1:0] random_value();
      logic [VW-1:0] v;
      case ($urandom_range(4))
         0, 1: v = $urandom;
         2: v = $urandom >> $urandom_range(VW - 1);
         3: begin
            v = $urandom >> $urandom_range(VW - 1);
            v = ~v + 1'b1;
         end
         default: begin
            // land near the most negative and most positive values
            v = {1'b1, {(VW - 1){1'b0}}} + VW'($urandom_range(3));
            if ($urandom_range(1)) begin
               v = ~v;
            end
         end
      endcase
      return v;
   endfunction

   function automatic logic [ITRA_RADIX_W-1:0] random_radix();
      logic [ITRA_RADIX_W-1:0] r;
      case ($urandom_range(9))
         0: r = ITRA_RADIX_W'($urandom_range(63));
         1: begin
            case ($urandom_range(2))
               0: r = 6'd2;
               1: r = 6'd10;
               default: r = 6'd16;
            endcase
         end
         default: r = ITRA_RADIX_W'($urandom_range(RADIX_MAX, RADIX_MIN));
      endcase
      return r;
   endfunction

   // Receiver: pop at random, driven on the falling edge
   always @(negedge clock) begin
      rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Compare each popped character beat with the oldest expectation
   always @(posedge clock) begin
      text_beat_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_text.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_CAP) begin
               $display("%0t: unexpected character beat: expected none, actual char %h last %b",
                        $time, rsp_character, rsp_last);
            end
         end else begin
            want = expected_text.pop_front();
            chars_checked++;
            if (rsp_character !== want.code) begin
               error_count++;
               if (error_count <= REPORT_CAP) begin
                  $display("%0t: character mismatch: expected %h actual %h",
                           $time, want.code, rsp_character);
               end
            end
            if (rsp_last !== want.last) begin
               error_count++;
               if (error_count <= REPORT_CAP) begin
                  $display("%0t: last flag mismatch: expected %b actual %b",
                           $time, want.last, rsp_last);
               end
            end
         end
      end
   end

   // Watchdog: end the run when no beat moves on either side for too long
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Zero, one, minus one, both extremes, and the radix ends
   task automatic test_value_extremes();
      send_number(32'sd0, 6'd10);
      send_number(32'sd0, 6'd2);
      send_number(32'sd0, 6'd36);
      send_number(32'sd1, 6'd2);
      send_number(-32'sd1, 6'd10);
      send_number(32'h8000_0000, 6'd10);
      send_number(32'h8000_0000, 6'd2);
      send_number(32'h8000_0000, 6'd16);
      send_number(32'h7FFF_FFFF, 6'd10);
      send_number(32'h7FFF_FFFF, 6'd2);
      send_number(32'h7FFF_FFFF, 6'd36);
      send_number(-32'sd2147483647, 6'd36);
      send_number(32'h89AB_CDEF, 6'd16);
   endtask

   // Letter digits and the top of the letter range
   task automatic test_letter_digits();
      send_number(32'sd35, 6'd36);
      send_number(32'sd1295, 6'd36);
      send_number(32'sd10, 6'd16);
      send_number(-32'sd255, 6'd16);
      send_number(32'sd9, 6'd10);
   endtask

   // Radix below two acts as binary, above thirty-six as base 36
   task automatic test_radix_clamping();
      send_number(32'sd5, 6'd0);
      send_number(-32'sd5, 6'd1);
      send_number(32'sd0, 6'd0);
      send_number(32'sd35, 6'd37);
      send_number(32'sd100, 6'd63);
      send_number(32'h8000_0000, 6'd63);
   endtask

   task automatic test_random_numbers(input int count, input int send_idle, input int recv_idle);
      int n;
      send_idle_pct = send_idle;
      recv_idle_pct = recv_idle;
      for (n = 0; n < count; n++) begin
         send_number(random_value(), random_radix());
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_value_extremes();
      test_letter_digits();
      test_radix_clamping();
      test_random_numbers(146, 28, 86);
      test_random_numbers(146, 86, 28);
      test_random_numbers(144, 0, 0);
      release_input();

      // drain, then give any stray beat time to show up
      wait (expected_text.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Converted %0d numbers, %0d characters checked, %0d mismatches.",
               numbers_sent, chars_checked, error_count);
      $display("Covered value extremes, radix 0 to 63 with clamping, and three stall mixes.");
      if (error_count == 0 && expected_text.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
